FILE: design/ptfs_pkg.sv
// ----------------------------------------------------------------------------
// ptfs_pkg
// Shared types and constants of the periodic telemetry frame scheduler.
// ----------------------------------------------------------------------------
package ptfs_pkg;

    localparam logic [7:0] FRAME_MARK   = 8'h5E;
    localparam logic [7:0] ESC_MARK     = 8'h5D;
    localparam logic [7:0] ESC_XOR      = 8'h60;
    localparam logic [15:0] MS_PER_TENTH = 16'd100;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // One slot of the ring as held in memory
    typedef struct packed {
        logic [7:0]  ident;
        logic [7:0]  period;
        logic [15:0] sample;
        logic [15:0] sent_time;
    } slot_entry_t;

    // Scheduler to framer request
    typedef struct packed {
        logic        start;
        logic [7:0]  ident;
        logic [15:0] sample;
    } frame_req_t;

endpackage

FILE: design/ptfs_slot_mem.sv
// ----------------------------------------------------------------------------
// ptfs_slot_mem
// Slot store: one write port, one registered read port. Sample and sent
// time of a slot read as zero until the slot is first written.
// ----------------------------------------------------------------------------
module ptfs_slot_mem #(
    parameter int SLOTS = 32,
    parameter int AW    = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [AW-1:0]        rd_addr,
    output ptfs_pkg::slot_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  ptfs_pkg::slot_entry_t wr_data
);

    ptfs_pkg::slot_entry_t mem [SLOTS];
    ptfs_pkg::slot_entry_t rd_raw_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // id and period have no defined reset value, so they pass through
    always_comb begin
        rd_data = rd_raw_reg;
        if (!rd_valid_reg) begin
            rd_data.sample    = '0;
            rd_data.sent_time = '0;
        end
    end

endmodule

FILE: design/ptfs_framer.sv
// ----------------------------------------------------------------------------
// ptfs_framer
// Builds one byte-stuffed frame (mark, id, value low, value high, mark) and
// feeds it byte by byte into the output register.
// ----------------------------------------------------------------------------
module ptfs_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptfs_pkg::frame_req_t req,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    typedef enum logic {
        F_IDLE,
        F_RUN
    } fstate_t;

    fstate_t     state_reg;
    logic [2:0]  field_reg;
    logic        esc_reg;
    logic [7:0]  ident_reg;
    logic [15:0] sample_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;

    logic        slot_open;
    logic [7:0]  inner_byte;
    logic        needs_esc;

    assign slot_open = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (field_reg)
            3'd1:    inner_byte = ident_reg;
            3'd2:    inner_byte = sample_reg[7:0];
            default: inner_byte = sample_reg[15:8];
        endcase
    end

    assign needs_esc = (inner_byte == ptfs_pkg::ESC_MARK) ||
                       (inner_byte == ptfs_pkg::FRAME_MARK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            field_reg    <= '0;
            esc_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (m_tvalid_reg && m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (req.start) begin
                        state_reg  <= F_RUN;
                        field_reg  <= 3'd0;
                        esc_reg    <= 1'b0;
                        ident_reg  <= req.ident;
                        sample_reg <= req.sample;
                    end
                end
                F_RUN: begin
                    // a byte is only taken here as the next one loads, so only a load changes valid
                    if (slot_open) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= (field_reg == 3'd4);
                        priority if (field_reg == 3'd0) begin
                            m_tdata_reg <= ptfs_pkg::FRAME_MARK;
                            field_reg   <= 3'd1;
                        end else if (field_reg == 3'd4) begin
                            m_tdata_reg <= ptfs_pkg::FRAME_MARK;
                            state_reg   <= F_IDLE;
                        end else if (esc_reg) begin
                            m_tdata_reg <= inner_byte ^ ptfs_pkg::ESC_XOR;
                            esc_reg     <= 1'b0;
                            field_reg   <= field_reg + 3'd1;
                        end else if (needs_esc) begin
                            m_tdata_reg <= ptfs_pkg::ESC_MARK;
                            esc_reg     <= 1'b1;
                        end else begin
                            m_tdata_reg <= inner_byte;
                            field_reg   <= field_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg == F_RUN);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_last_is_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> (m_tdata_reg == ptfs_pkg::FRAME_MARK))
        else $error("frame end not on a frame mark");

    a_esc_in_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (busy && field_reg >= 3'd1 && field_reg <= 3'd3))
        else $error("escape pending outside inner bytes");

endmodule

FILE: design/periodic_telemetry_frame_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_telemetry_frame_scheduler
// Round-robin telemetry scheduler with byte-stuffed frame output.
// ----------------------------------------------------------------------------
// Input items arrive on s_* (s_tuser = action). Load and set-value items
// write a slot; a tick item scans the ring from the saved pointer and, if the
// slot it stops on is due, sends one frame on m_*: 0x5E, id, value low,
// value high, 0x5E, with 0x5D/0x5E inside escaped as 0x5D, byte ^ 0x60.
// m_tlast marks the closing 0x5E. The slot count is written on cfg_*; the
// user writes it only while the block is idle, the block does not enforce it.
// Load and set run as one memory read-modify-write. A tick visits one slot
// per cycle (up to the active count), set by the single read port of the
// slot memory. When a frame goes out, the framer hands its five to eight
// bytes to the output register, then the scan is released. The next item
// is taken after the last byte sits in the output register.
// Reset clears the scan pointer, slot count and per-slot valid bits, so
// sample and sent time of every slot read as zero; no clearing pass.
// A stalled receiver holds the output byte and the frame build waits.
// ----------------------------------------------------------------------------
module periodic_telemetry_frame_scheduler #(
    parameter int SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg: slot_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] slot_index, [12:5] data_id, [20:13] refresh_tenths,
    // [36:21] sample_value, [52:37] now_ms, [55:53] zero
    input  logic [55:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // frame_end
    output logic        m_tlast
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_SEND
    } state_t;

    state_t      state_reg;
    logic [5:0]  slot_count_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] p_reg;
    logic [AW-1:0] start_reg;
    logic [1:0]  act_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]  ident_reg;
    logic [7:0]  period_reg;
    logic [15:0] sample_reg;
    logic [15:0] now_reg;

    logic [4:0]  in_index;
    logic [7:0]  in_ident;
    logic [7:0]  in_period;
    logic [15:0] in_sample;
    logic [15:0] in_now;
    logic        in_accept;
    logic        index_ok;

    logic [CW-1:0] count;
    logic [AW-1:0] scan_first;
    logic [AW:0]   p_plus;
    logic [AW-1:0] p_next;
    logic [15:0]   elapsed;
    logic [15:0]   limit;
    logic          over;
    logic          due;
    logic          stop;

    logic [AW-1:0]         rd_addr;
    ptfs_pkg::slot_entry_t rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    ptfs_pkg::slot_entry_t wr_data;
    ptfs_pkg::frame_req_t  req;
    logic                  fr_busy;

    assign in_index  = s_tdata[4:0];
    assign in_ident  = s_tdata[12:5];
    assign in_period = s_tdata[20:13];
    assign in_sample = s_tdata[36:21];
    assign in_now    = s_tdata[52:37];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign index_ok  = (32'(in_index) < SLOTS);

    assign count = (32'(slot_count_reg) > SLOTS) ? CW'(SLOTS) : CW'(slot_count_reg);
    assign scan_first = (32'(ptr_reg) >= 32'(count)) ? '0 : ptr_reg;

    // scan step: data for p_reg is on rd_data
    assign p_plus  = {1'b0, p_reg} + (AW+1)'(1);
    assign p_next  = (32'(p_plus) < 32'(count)) ? AW'(p_plus) : '0;
    assign elapsed = now_reg - rd_data.sent_time;
    assign limit   = 16'(rd_data.period) * ptfs_pkg::MS_PER_TENTH;
    assign over    = (elapsed > limit);
    assign due     = (elapsed >= limit);
    assign stop    = over || (p_next == start_reg);

    always_comb begin
        rd_addr    = p_next;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        req.start  = 1'b0;
        req.ident  = rd_data.ident;
        req.sample = rd_data.sample;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = (s_tuser == ptfs_pkg::ACT_TICK) ? scan_first : AW'(in_index);
            end
            ST_MOD: begin
                wr_en = 1'b1;
                if (act_reg == ptfs_pkg::ACT_LOAD) begin
                    wr_data.ident  = ident_reg;
                    wr_data.period = period_reg;
                end else begin
                    wr_data.sample = sample_reg;
                end
            end
            ST_SCAN: begin
                wr_addr           = p_reg;
                wr_data.sent_time = now_reg;
                if (stop && due) begin
                    wr_en     = 1'b1;
                    req.start = 1'b1;
                end
            end
            ST_SEND: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= '0;
            ptr_reg        <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                slot_count_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        act_reg    <= s_tuser;
                        idx_reg    <= AW'(in_index);
                        ident_reg  <= in_ident;
                        period_reg <= in_period;
                        sample_reg <= in_sample;
                        now_reg    <= in_now;
                        p_reg      <= scan_first;
                        start_reg  <= scan_first;
                        priority if ((s_tuser == ptfs_pkg::ACT_LOAD ||
                                      s_tuser == ptfs_pkg::ACT_SET) && index_ok) begin
                            state_reg <= ST_MOD;
                        end else if (s_tuser == ptfs_pkg::ACT_TICK && count != '0) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_MOD: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (stop) begin
                        if (due) begin
                            ptr_reg   <= p_next;
                            state_reg <= ST_SEND;
                        end else begin
                            ptr_reg   <= p_reg;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        p_reg <= p_next;
                    end
                end
                ST_SEND: begin
                    if (!fr_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    ptfs_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ptfs_framer u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .busy     (fr_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_idle_framer_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !fr_busy)
        else $error("item taken while a frame is still being built");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(ptr_reg) < SLOTS))
        else $error("scan pointer out of range");

    a_start_stamps: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (wr_en && wr_addr == p_reg && state_reg == ST_SCAN))
        else $error("frame started without stamping the slot");

endmodule

FILE: verif/periodic_telemetry_frame_scheduler_tb.sv
// ----------------------------------------------------------------------------
// periodic_telemetry_frame_scheduler_tb
// Self-checking bench for the telemetry frame scheduler. Load, set-value and
// tick items are fed from a queue, each accepted item runs through a local
// slot-ring predictor, and every output byte is checked against the oldest
// predicted frame byte. Slot count is rewritten between phases while idle;
// both sides throttle at random and the receiver stalls hard once.
// ----------------------------------------------------------------------------
module periodic_telemetry_frame_scheduler_tb;

    localparam int SLOTS = 32;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int SCAN_SETTLE = 48;     // margin for the worst tick: a full-ring scan and an eight-byte frame
    localparam int HOLD_CYCLES = 400;

    // Fields of one input item, action in the top bits
    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  slot;
        logic [7:0]  ident;
        logic [7:0]  period;
        logic [15:0] sample;
        logic [15:0] now;
    } telem_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // Predictor copy of the ring
    logic [7:0]  ring_ident [SLOTS];
    logic [7:0]  ring_period[SLOTS];
    logic [15:0] ring_sample[SLOTS];
    logic [15:0] ring_sent  [SLOTS];
    int unsigned ring_ptr = 0;
    int unsigned ring_size = 0;

    telem_item_t item_fifo[$];
    frame_byte_t frame_bytes[$];
    telem_item_t cur_item;
    logic [31:0] slot_loaded = '0;
    logic [15:0] tick_clock = '0;

    int unsigned items_issued = 0;
    int unsigned items_taken = 0;
    int unsigned errors = 0;
    int unsigned s_gap = 0;
    int unsigned s_gap_max = 15;
    int unsigned m_gap = 0;
    int unsigned m_gap_max = 15;
    int unsigned rx_draw;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    frame_byte_t got_byte;

    periodic_telemetry_frame_scheduler #(
        .SLOTS(SLOTS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #6 aclk = ~aclk;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            ring_ident[i] = '0;
            ring_period[i] = '0;
            ring_sample[i] = '0;
            ring_sent[i] = '0;
        end
    end

    function automatic telem_item_t mk(input logic [1:0] act, input logic [4:0] slot,
                                       input logic [7:0] id, input logic [7:0] per,
                                       input logic [15:0] val, input logic [15:0] now);
        return {act, slot, id, per, val, now};
    endfunction

    function automatic int age_of(input int unsigned p, input logic [15:0] now);
        logic [15:0] d;
        d = now - ring_sent[p];
        return int'(d);
    endfunction

    function automatic int limit_of(input int unsigned p);
        return int'(ring_period[p]) * int'(ptfs_pkg::MS_PER_TENTH);
    endfunction

    task automatic push_inner(input logic [7:0] b);
        if (b == ptfs_pkg::ESC_MARK || b == ptfs_pkg::FRAME_MARK) begin
            frame_bytes.push_back({ptfs_pkg::ESC_MARK, 1'b0});
            frame_bytes.push_back({b ^ ptfs_pkg::ESC_XOR, 1'b0});
        end else begin
            frame_bytes.push_back({b, 1'b0});
        end
    endtask

    // Applies one accepted item to the ring and queues the frame bytes it sends
    task automatic schedule_item(input telem_item_t it);
        int unsigned active, first, p, nx;
        case (it.action)
            ptfs_pkg::ACT_LOAD: begin
                ring_ident[it.slot] = it.ident;
                ring_period[it.slot] = it.period;
            end
            ptfs_pkg::ACT_SET: begin
                ring_sample[it.slot] = it.sample;
            end
            ptfs_pkg::ACT_TICK: begin
                active = (ring_size > SLOTS) ? SLOTS : ring_size;
                if (active != 0) begin
                    if (ring_ptr >= active)
                        ring_ptr = 0;
                    first = ring_ptr;
                    p = first;
                    nx = (p + 1 < active) ? p + 1 : 0;
                    // stop on the first overdue slot or the last one before wrapping
                    while (age_of(p, it.now) <= limit_of(p) && nx != first) begin
                        p = nx;
                        nx = (p + 1 < active) ? p + 1 : 0;
                    end
                    ring_ptr = p;
                    if (age_of(p, it.now) >= limit_of(p)) begin
                        frame_bytes.push_back({ptfs_pkg::FRAME_MARK, 1'b0});
                        push_inner(ring_ident[p]);
                        push_inner(ring_sample[p][7:0]);
                        push_inner(ring_sample[p][15:8]);
                        frame_bytes.push_back({ptfs_pkg::FRAME_MARK, 1'b1});
                        ring_sent[p] = it.now;
                        ring_ptr = (p + 1 < active) ? p + 1 : 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
    endtask

    task automatic push_item(input telem_item_t it);
        if (it.action == ptfs_pkg::ACT_LOAD)
            slot_loaded[it.slot] = 1'b1;
        item_fifo.push_back(it);
        items_issued++;
    endtask

    task automatic push_random();
        int unsigned r;
        telem_item_t it;
        r = $urandom_range(0, 99);
        it = mk(2'($urandom), 5'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom));
        if (r < 50) begin
            it.action = ptfs_pkg::ACT_TICK;
            if ($urandom_range(0, 9) == 0)
                tick_clock = 16'($urandom);
            else
                tick_clock = tick_clock + 16'($urandom_range(0, 2500));
            it.now = tick_clock;
        end else if (r < 75) begin
            it.action = ptfs_pkg::ACT_SET;
            if ($urandom_range(0, 3) == 0)
                it.sample[7:0] = $urandom_range(0, 1) ? ptfs_pkg::ESC_MARK
                                                      : ptfs_pkg::FRAME_MARK;
            if ($urandom_range(0, 3) == 0)
                it.sample[15:8] = $urandom_range(0, 1) ? ptfs_pkg::ESC_MARK
                                                       : ptfs_pkg::FRAME_MARK;
        end else if (r < 95) begin
            it.action = ptfs_pkg::ACT_LOAD;
            if ($urandom_range(0, 3) != 0)
                it.period = 8'($urandom_range(0, 25));
            if ($urandom_range(0, 3) == 0)
                it.ident = $urandom_range(0, 1) ? ptfs_pkg::ESC_MARK
                                                : ptfs_pkg::FRAME_MARK;
        end else begin
            it.action = ACT_NONE;
        end
        push_item(it);
    endtask

    // Waits until every item is taken and every byte has come out
    task automatic wait_idle();
        while (items_taken != items_issued || frame_bytes.size() != 0)
            @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);
    endtask

    task automatic set_ring_size(input logic [5:0] v);
        int unsigned s;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_size = v;
        // every active slot gets a load before any tick can reach it
        for (s = 0; s < ((v > SLOTS) ? SLOTS : v); s++)
            if (!slot_loaded[s])
                push_item(mk(ptfs_pkg::ACT_LOAD, s[4:0], 8'($urandom),
                             8'($urandom_range(0, 25)), 16'($urandom), 16'($urandom)));
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                schedule_item(cur_item);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap != 0) begin
                    s_tvalid <= 1'b0;
                    s_gap <= s_gap - 1;
                end else if (item_fifo.size() != 0) begin
                    cur_item = item_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, cur_item.now, cur_item.sample, cur_item.period,
                                cur_item.ident, cur_item.slot};
                    s_tuser <= cur_item.action;
                    s_gap <= $urandom_range(0, s_gap_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver throttle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_bytes.size() == 0) begin
                    report_mismatch("byte with no frame pending", m_tdata, 8'h00);
                end else begin
                    got_byte = frame_bytes.pop_front();
                    if (m_tdata !== got_byte.data)
                        report_mismatch("out_byte", m_tdata, got_byte.data);
                    if (m_tlast !== got_byte.last)
                        report_mismatch("frame_end", {7'b0, m_tlast}, {7'b0, got_byte.last});
                end
            end
            if (hold_seen != hold_token) begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                rx_draw = $urandom_range(0, m_gap_max);
                m_gap <= rx_draw;
                m_tready <= (rx_draw == 0);
            end else if (m_gap != 0) begin
                m_gap <= m_gap - 1;
                m_tready <= (m_gap == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned ph, k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty ring, unknown action, extreme loads and values
        set_ring_size(6'd0);
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'hFFFF));
        push_item(mk(ACT_NONE, 5'h1F, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        push_item(mk(ptfs_pkg::ACT_LOAD, 5'd0, ptfs_pkg::FRAME_MARK, 8'd0,
                     16'h0000, 16'h0000));
        push_item(mk(ptfs_pkg::ACT_LOAD, 5'd1, ptfs_pkg::ESC_MARK, 8'd255,
                     16'h0000, 16'h0000));
        push_item(mk(ptfs_pkg::ACT_LOAD, 5'd31, 8'hFF, 8'd1, 16'hFFFF, 16'h0000));
        push_item(mk(ptfs_pkg::ACT_SET, 5'd0, 8'h00, 8'h00,
                     {ptfs_pkg::ESC_MARK, ptfs_pkg::FRAME_MARK}, 16'h0000));
        push_item(mk(ptfs_pkg::ACT_SET, 5'd1, 8'h00, 8'h00, 16'hFFFF, 16'h0000));
        push_item(mk(ptfs_pkg::ACT_SET, 5'd31, 8'h00, 8'h00, 16'h5E00, 16'h0000));
        wait_idle();

        // two slots: escaped frames, long period, time wrap
        set_ring_size(6'd2);
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'd100));
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'hFFFF));
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'hFFFF));
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'h0000));
        wait_idle();

        // one slot: stale pointer, then elapsed equal to a zero period
        set_ring_size(6'd1);
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'h8000));
        push_item(mk(ptfs_pkg::ACT_TICK, 5'd0, 8'h00, 8'h00, 16'h0000, 16'h8000));
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            s_gap_max = (ph % 3 == 0) ? 0 : 15;
            m_gap_max = (ph % 2 == 0) ? 15 : 0;
            case (ph)
                0: set_ring_size(6'd32);
                1: set_ring_size(6'd63);     // above SLOTS, acts as full ring
                2: set_ring_size(6'd6);
                3: set_ring_size(6'd0);
                4: set_ring_size(6'd1);
                5: set_ring_size(6'd32);
                6: set_ring_size(6'($urandom_range(2, 31)));
                default: set_ring_size(6'($urandom_range(33, 63)));
            endcase
            if (ph == 5)
                hold_token++;
            for (k = 0; k < 35; k++)
                push_random();
            wait_idle();
        end

        if (errors == 0)
            $display("periodic_telemetry_frame_scheduler verification clean");
        else
            $display("periodic_telemetry_frame_scheduler verification failed");
        $finish;
    end

    initial begin
        #(12 * 700000);
        $display("periodic_telemetry_frame_scheduler verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/ptfs_pkg.sv
design/ptfs_slot_mem.sv
design/ptfs_framer.sv
design/periodic_telemetry_frame_scheduler.sv
verif/periodic_telemetry_frame_scheduler_tb.sv
